FILE: hdl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg - shared types and constants of the delta list timer queue
// Word formats of both channels, cell opcodes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int DELTA_W       = 32;
  localparam int ARG_W         = 32;
  localparam int TASK_FIELD_W  = 8;
  localparam int STATUS_W      = 2;
  localparam int QUEUE_DEPTH   = 16;
  localparam int TASK_ID_BITS  = 8;
  localparam int MAX_RESULTS   = 16;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_ADD  = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FIRED    = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef struct packed {
    logic                    mode;
    logic [DELTA_W-1:0]      delay;
    logic [TASK_FIELD_W-1:0] task_id;
    logic [ARG_W-1:0]        task_argument;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [TASK_FIELD_W-1:0] fired_task;
    logic [ARG_W-1:0]        fired_argument;
    logic                    last;
  } out_word_t;

  // what a cell does when clocked
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,          // take new task, delta from sub
    CELL_FROM_LEFT,     // shift toward tail
    CELL_FROM_LEFT_SUB, // shift toward tail, delta minus sub
    CELL_FROM_RIGHT,    // shift toward head
    CELL_DEC            // count head down, stop at zero
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DELTA_W-1:0] sub;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_ADD_RESP,
    FSM_FIRE
  } fsm_e;

endpackage

FILE: hdl/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell - one entry of the delta list
// Holds delta, task handle and argument; loads from either neighbor.
// ----------------------------------------------------------------------------
module dltq_cell #(
  parameter int TASK_ID_BITS = dltq_pkg::TASK_ID_BITS
) (
  input  logic                         clk_i,
  input  dltq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [TASK_ID_BITS-1:0]      new_task_i,
  input  logic [dltq_pkg::ARG_W-1:0]   new_arg_i,
  input  logic [dltq_pkg::DELTA_W-1:0] left_delta_i,
  input  logic [TASK_ID_BITS-1:0]      left_task_i,
  input  logic [dltq_pkg::ARG_W-1:0]   left_arg_i,
  input  logic [dltq_pkg::DELTA_W-1:0] right_delta_i,
  input  logic [TASK_ID_BITS-1:0]      right_task_i,
  input  logic [dltq_pkg::ARG_W-1:0]   right_arg_i,
  output logic [dltq_pkg::DELTA_W-1:0] delta_o,
  output logic [TASK_ID_BITS-1:0]      task_o,
  output logic [dltq_pkg::ARG_W-1:0]   arg_o
);

  logic [dltq_pkg::DELTA_W-1:0] delta_q, delta_d;
  logic [TASK_ID_BITS-1:0]      task_q, task_d;
  logic [dltq_pkg::ARG_W-1:0]   arg_q, arg_d;

  always_comb begin
    delta_d = delta_q;
    task_d  = task_q;
    arg_d   = arg_q;
    case (ctrl_i.op)
      dltq_pkg::CELL_LOAD: begin
        delta_d = ctrl_i.sub;
        task_d  = new_task_i;
        arg_d   = new_arg_i;
      end
      dltq_pkg::CELL_FROM_LEFT: begin
        delta_d = left_delta_i;
        task_d  = left_task_i;
        arg_d   = left_arg_i;
      end
      dltq_pkg::CELL_FROM_LEFT_SUB: begin
        delta_d = left_delta_i - ctrl_i.sub;
        task_d  = left_task_i;
        arg_d   = left_arg_i;
      end
      dltq_pkg::CELL_FROM_RIGHT: begin
        delta_d = right_delta_i;
        task_d  = right_task_i;
        arg_d   = right_arg_i;
      end
      dltq_pkg::CELL_DEC: begin
        if (delta_q != '0) begin
          delta_d = delta_q - dltq_pkg::DELTA_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    task_q  <= task_d;
    arg_q   <= arg_d;
  end

  assign delta_o = delta_q;
  assign task_o  = task_q;
  assign arg_o   = arg_q;

endmodule

FILE: hdl/delta_list_timer_queue_top.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top - one-shot timer queue kept as a delta list
// Chain of entry cells plus a sequencer for add walks and tick firing.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_stall_o / in_data_i): one word is a tick
//   (mode 0) or an add (mode 1). in_stall_o is high while a word is being
//   worked on, so the block takes one word at a time.
//   out channel (out_valid_o / out_stall_i / out_data_o): result words from
//   one output register. An add gives one word (accepted or rejected); a
//   tick gives zero to MAX_RESULTS fired-task words, the final one with
//   last set. A tick on an empty queue, or one that only counts the head
//   down, gives no word.
//   Timing: an add walks the chain one entry a cycle through the single
//   compare/subtract unit, then loads its result once the output register
//   is free; a rejected add skips the walk. A tick first counts the head
//   down, then loads one fired word a cycle while the output register is
//   free, each fire also shifting the whole chain one place toward the head;
//   a tick on a non-empty queue that fires nothing still passes the fire state.
//   Stall: a held result keeps its word; the sequencer waits for the output
//   register to free before loading the next one. A new input word may be
//   accepted while the last result still waits.
//   Reset: the entry count is cleared; entry contents are not reset.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top #(
  parameter int QUEUE_DEPTH  = dltq_pkg::QUEUE_DEPTH,
  parameter int TASK_ID_BITS = dltq_pkg::TASK_ID_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dltq_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dltq_pkg::out_word_t out_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W = $clog2(dltq_pkg::MAX_RESULTS + 1);

  // chain taps
  logic [dltq_pkg::DELTA_W-1:0] delta_w [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0]      task_w  [QUEUE_DEPTH];
  logic [dltq_pkg::ARG_W-1:0]   arg_w   [QUEUE_DEPTH];
  logic [dltq_pkg::DELTA_W-1:0] ldelta_w [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0]      ltask_w  [QUEUE_DEPTH];
  logic [dltq_pkg::ARG_W-1:0]   larg_w   [QUEUE_DEPTH];
  logic [dltq_pkg::DELTA_W-1:0] rdelta_w [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0]      rtask_w  [QUEUE_DEPTH];
  logic [dltq_pkg::ARG_W-1:0]   rarg_w   [QUEUE_DEPTH];
  dltq_pkg::cell_ctrl_t         ctrl_w   [QUEUE_DEPTH];

  // sequencer state
  dltq_pkg::fsm_e               state_q, state_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [PTR_W-1:0]             ptr_q, ptr_d;
  logic [dltq_pkg::DELTA_W-1:0] rem_q, rem_d;    // delay left after entries passed
  logic [NUM_W-1:0]             num_q, num_d;    // tasks fired this tick
  logic                         full_q, full_d;
  logic [TASK_ID_BITS-1:0]      new_task_q, new_task_d;
  logic [dltq_pkg::ARG_W-1:0]   new_arg_q, new_arg_d;
  logic                         out_valid_q, out_valid_d;
  dltq_pkg::out_word_t          out_q, out_d;

  logic in_acc, out_free, walk_stop, fire, fire_last;
  logic [dltq_pkg::DELTA_W-1:0] ptr_delta;

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign ldelta_w[i] = '0;
      assign ltask_w[i]  = '0;
      assign larg_w[i]   = '0;
    end else begin : g_mid
      assign ldelta_w[i] = delta_w[i-1];
      assign ltask_w[i]  = task_w[i-1];
      assign larg_w[i]   = arg_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rdelta_w[i] = '0;
      assign rtask_w[i]  = '0;
      assign rarg_w[i]   = '0;
    end else begin : g_body
      assign rdelta_w[i] = delta_w[i+1];
      assign rtask_w[i]  = task_w[i+1];
      assign rarg_w[i]   = arg_w[i+1];
    end

    dltq_cell #(
      .TASK_ID_BITS(TASK_ID_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_w[i]),
      .new_task_i   (new_task_q),
      .new_arg_i    (new_arg_q),
      .left_delta_i (ldelta_w[i]),
      .left_task_i  (ltask_w[i]),
      .left_arg_i   (larg_w[i]),
      .right_delta_i(rdelta_w[i]),
      .right_task_i (rtask_w[i]),
      .right_arg_i  (rarg_w[i]),
      .delta_o      (delta_w[i]),
      .task_o       (task_w[i]),
      .arg_o        (arg_w[i])
    );
  end

  // --------------------------------------------------------------------------
  // decisions
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != dltq_pkg::FSM_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // walk: insert in front of the first entry whose delta exceeds what is left
  assign ptr_delta = delta_w[ptr_q];
  assign walk_stop = (CNT_W'(ptr_q) == cnt_q) || (ptr_delta > rem_q);

  // head due now; last when the next entry is not due or the cap is hit
  assign fire = (cnt_q != '0) && (delta_w[0] == '0);
  if (QUEUE_DEPTH > 1) begin : g_last
    assign fire_last = !((cnt_q > CNT_W'(1)) && (delta_w[1] == '0) &&
                         (num_q < NUM_W'(dltq_pkg::MAX_RESULTS - 1)));
  end else begin : g_last1
    assign fire_last = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dltq_pkg::FSM_IDLE: begin
        if (in_acc) begin
          if (in_data_i.mode == dltq_pkg::MODE_ADD) begin
            state_d = (cnt_q == CNT_W'(QUEUE_DEPTH)) ? dltq_pkg::FSM_ADD_RESP
                                                    : dltq_pkg::FSM_WALK;
          end else if (cnt_q != '0) begin
            state_d = dltq_pkg::FSM_FIRE;
          end
        end
      end
      dltq_pkg::FSM_WALK: begin
        if (walk_stop) begin
          state_d = dltq_pkg::FSM_ADD_RESP;
        end
      end
      dltq_pkg::FSM_ADD_RESP: begin
        if (out_free) begin
          state_d = dltq_pkg::FSM_IDLE;
        end
      end
      dltq_pkg::FSM_FIRE: begin
        if (!fire) begin
          state_d = dltq_pkg::FSM_IDLE;
        end else if (out_free && fire_last) begin
          state_d = dltq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = dltq_pkg::FSM_IDLE;
      end
    endcase
  end

  // datapath and cell control
  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    num_d       = num_q;
    full_d      = full_q;
    new_task_d  = new_task_q;
    new_arg_d   = new_arg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctrl_w[i].op  = dltq_pkg::CELL_HOLD;
      ctrl_w[i].sub = rem_q;
    end
    case (state_q)
      dltq_pkg::FSM_IDLE: begin
        if (in_acc) begin
          new_task_d = TASK_ID_BITS'(in_data_i.task_id);
          new_arg_d  = in_data_i.task_argument;
          rem_d      = in_data_i.delay;
          ptr_d      = '0;
          num_d      = '0;
          full_d     = (cnt_q == CNT_W'(QUEUE_DEPTH));
          if ((in_data_i.mode == dltq_pkg::MODE_TICK) && (cnt_q != '0)) begin
            ctrl_w[0].op = dltq_pkg::CELL_DEC;
          end
        end
      end
      dltq_pkg::FSM_WALK: begin
        if (walk_stop) begin
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i < int'(ptr_q)) begin
              ctrl_w[i].op = dltq_pkg::CELL_HOLD;
            end else if (i == int'(ptr_q)) begin
              ctrl_w[i].op = dltq_pkg::CELL_LOAD;
            end else if (i == int'(ptr_q) + 1) begin
              ctrl_w[i].op = dltq_pkg::CELL_FROM_LEFT_SUB;
            end else begin
              ctrl_w[i].op = dltq_pkg::CELL_FROM_LEFT;
            end
          end
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          rem_d = rem_q - ptr_delta;
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      dltq_pkg::FSM_ADD_RESP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.status         = full_q ? dltq_pkg::ST_REJECTED : dltq_pkg::ST_ACCEPTED;
          out_d.fired_task     = '0;
          out_d.fired_argument = '0;
          out_d.last           = 1'b1;
        end
      end
      dltq_pkg::FSM_FIRE: begin
        if (fire && out_free) begin
          out_valid_d          = 1'b1;
          out_d.status         = dltq_pkg::ST_FIRED;
          out_d.fired_task     = dltq_pkg::TASK_FIELD_W'(task_w[0]);
          out_d.fired_argument = arg_w[0];
          out_d.last           = fire_last;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ctrl_w[i].op = dltq_pkg::CELL_FROM_RIGHT;
          end
          cnt_d = cnt_q - CNT_W'(1);
          num_d = num_q + NUM_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dltq_pkg::FSM_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      num_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      num_q       <= num_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    new_task_q <= new_task_d;
    new_arg_q  <= new_arg_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_walk_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dltq_pkg::FSM_WALK) |-> (CNT_W'(ptr_q) <= cnt_q))
    else $error("walk pointer passed the tail");

  a_fire_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dltq_pkg::FSM_FIRE && num_q != '0) |-> fire)
    else $error("fire chain continued with head not due");

  a_walk_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dltq_pkg::FSM_WALK) |-> (cnt_q != CNT_W'(QUEUE_DEPTH)))
    else $error("insert walk on a full queue");

endmodule
